// ===== rtl/core/lcdfe_pkg.sv =====
// shared types, constants and tables of the character lcd command front end
`default_nettype none
package lcdfe_pkg;

	// geometry of the shadow and the display lines
	localparam int SHADOW_CELLS = 64;
	localparam int LINE_CELLS   = 16;
	localparam int CELL_AW      = $clog2(SHADOW_CELLS);
	localparam int FLAG_SELS    = 3;

	// transfer buffer holds every nibble of one request
	localparam int TX_DEPTH = 24;
	localparam int TX_AW    = $clog2(TX_DEPTH + 1);

	// sequencer step counter and op list
	localparam int PH_W     = 4;
	localparam int INIT_LEN = 14;
	localparam int OPS_LEN  = 8;

	// request codes
	localparam logic [3:0] REQ_INIT     = 4'd0;
	localparam logic [3:0] REQ_WRITE    = 4'd1;
	localparam logic [3:0] REQ_WRITE_AT = 4'd2;
	localparam logic [3:0] REQ_SETPOS   = 4'd3;
	localparam logic [3:0] REQ_SETXY    = 4'd4;
	localparam logic [3:0] REQ_UP       = 4'd5;
	localparam logic [3:0] REQ_DOWN     = 4'd6;
	localparam logic [3:0] REQ_LEFT     = 4'd7;
	localparam logic [3:0] REQ_RIGHT    = 4'd8;
	localparam logic [3:0] REQ_CLEAR    = 4'd9;
	localparam logic [3:0] REQ_FLAG     = 4'd10;
	localparam logic [3:0] REQ_DIG_UP   = 4'd11;
	localparam logic [3:0] REQ_DIG_DOWN = 4'd12;
	localparam logic [3:0] REQ_READ     = 4'd13;

	// lcd command bytes and characters
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
	localparam logic [7:0] CMD_FUNCTION   = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0F;
	localparam logic [7:0] CMD_ENTRY      = 8'h06;
	localparam logic [7:0] CMD_DISPLAY    = 8'h08;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_NINE      = 8'h39;
	localparam logic [6:0] ROW1_BASE      = 7'h40;
	localparam logic [2:0] FLAG_KEEP_MASK = 3'b110;
	localparam logic [2:0] FLAG_RESET     = 3'b111;

	// primitive operations of the sequencer
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SP_ARG,
		OP_SP_SAVED,
		OP_SP_CUR,
		OP_STEPBACK,
		OP_DATA_IN,
		OP_DATA_SPACE,
		OP_DATA_DIG,
		OP_CLEAR,
		OP_FLAG,
		OP_INIT,
		OP_DIGIT,
		OP_READ
	} op_t;

	// outcome of a digit check
	typedef enum logic [1:0] {
		DIG_NONE,
		DIG_STEP,
		DIG_WRAP
	} dig_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_DECODE = 4'b0010,
		ST_EXEC   = 4'b0100,
		ST_DRAIN  = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic            load;
		logic            exec;
		op_t             op;
		logic [PH_W-1:0] phase;
		logic            drain;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [3:0] req;
		logic       move_ok;
		logic       flag_ok;
		logic       use_pos;
		logic       op_done;
		dig_t       dig;
		logic       drain_done;
	} stat_t;

	// fixed nibbles of the init run, the final display command is built live
	function automatic logic [3:0] init_nibble(input logic [PH_W-1:0] ph);
		logic [3:0] n;
		case (ph)
			4'd0, 4'd1, 4'd2: n = 4'd3;
			4'd3:             n = 4'd2;
			4'd4:             n = CMD_FUNCTION[7:4];
			4'd5:             n = CMD_FUNCTION[3:0];
			4'd6:             n = CMD_DISPLAY_ON[7:4];
			4'd7:             n = CMD_DISPLAY_ON[3:0];
			4'd8:             n = CMD_CLEAR[7:4];
			4'd9:             n = CMD_CLEAR[3:0];
			4'd10:            n = CMD_ENTRY[7:4];
			4'd11:            n = CMD_ENTRY[3:0];
			default:          n = 4'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lcdfe_ctrl.sv =====
// controller: request decode into an op list, op sequencing and drain control
`default_nettype none
module lcdfe_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  lcdfe_pkg::stat_t stat,
	output lcdfe_pkg::cmd_t  cmd
);
	import lcdfe_pkg::*;

	state_t          state_q, state_d;
	logic [PH_W-1:0] ph_q;
	op_t             ops_q [OPS_LEN];
	op_t             build [OPS_LEN];
	op_t             expd  [OPS_LEN];
	op_t             ops_d [OPS_LEN];
	int              k;

	// handshake and commands
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		cmd.load  = in_valid && (state_q == ST_IDLE);
		cmd.exec  = (state_q == ST_EXEC) && (ops_q[0] != OP_NONE);
		cmd.op    = ops_q[0];
		cmd.phase = ph_q;
		cmd.drain = (state_q == ST_DRAIN);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECODE;
			ST_DECODE: state_d = ST_EXEC;
			ST_EXEC:   if (ops_q[0] == OP_NONE) state_d = ST_DRAIN;
			ST_DRAIN:  if (stat.drain_done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// op list of a fresh request
	always_comb begin
		for (int i = 0; i < OPS_LEN; i++) build[i] = OP_NONE;
		unique case (stat.req)
			REQ_INIT: build[0] = OP_INIT;
			REQ_WRITE: begin
				build[0] = OP_SP_CUR;
				build[1] = OP_DATA_IN;
			end
			REQ_WRITE_AT: begin
				build[0] = OP_SP_ARG;
				build[1] = OP_SP_CUR;
				build[2] = OP_DATA_IN;
				build[3] = OP_SP_SAVED;
			end
			REQ_SETPOS, REQ_SETXY: build[0] = OP_SP_ARG;
			REQ_UP, REQ_DOWN, REQ_LEFT, REQ_RIGHT: begin
				if (stat.move_ok) build[0] = OP_SP_ARG;
			end
			REQ_CLEAR: build[0] = OP_CLEAR;
			REQ_FLAG: begin
				if (stat.flag_ok) build[0] = OP_FLAG;
			end
			REQ_DIG_UP, REQ_DIG_DOWN: begin
				if (stat.use_pos) begin
					build[0] = OP_SP_ARG;
					build[1] = OP_DIGIT;
					build[2] = OP_SP_SAVED;
				end else begin
					build[0] = OP_DIGIT;
				end
			end
			REQ_READ: build[0] = OP_READ;
			default: ;
		endcase
	end

	// list advance: drops the finished head op; a digit op at the head is replaced by its expansion
	always_comb begin
		for (int i = 0; i < OPS_LEN; i++) expd[i] = OP_NONE;
		k = 0;
		case (stat.dig)
			DIG_WRAP: begin
				k = 6;
				expd[0] = OP_SP_CUR;
				expd[1] = OP_DATA_SPACE;
				expd[2] = OP_STEPBACK;
				expd[3] = OP_SP_CUR;
				expd[4] = OP_DATA_DIG;
				expd[5] = OP_STEPBACK;
			end
			DIG_STEP: begin
				k = 3;
				expd[0] = OP_SP_CUR;
				expd[1] = OP_DATA_DIG;
				expd[2] = OP_STEPBACK;
			end
			default: k = 0;
		endcase
		for (int i = 0; i < OPS_LEN; i++) begin
			if (i < k) ops_d[i] = expd[i];
			else if (i - k + 1 < OPS_LEN) ops_d[i] = ops_q[i - k + 1];
			else ops_d[i] = OP_NONE;
		end
	end

	// state, step counter and op list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= '0;
			for (int i = 0; i < OPS_LEN; i++) ops_q[i] <= OP_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECODE) begin
				ph_q <= '0;
				for (int i = 0; i < OPS_LEN; i++) ops_q[i] <= build[i];
			end else if (cmd.exec) begin
				if (stat.op_done) begin
					ph_q <= '0;
					for (int i = 0; i < OPS_LEN; i++) ops_q[i] <= ops_d[i];
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/lcdfe_dp.sv =====
// datapath: cursor, flags, shadow memory, nibble generation, transfer buffer, output register
`default_nettype none
module lcdfe_dp (
	input  wire              clk,
	input  wire              arst_n,
	input  lcdfe_pkg::cmd_t  cmd,
	output lcdfe_pkg::stat_t stat,
	input  wire  [3:0]       req_type,
	input  wire  [7:0]       char_code,
	input  wire  [7:0]       position,
	input  wire  [3:0]       column,
	input  wire  [3:0]       row,
	input  wire  [1:0]       flag_select,
	input  wire              flag_value,
	input  wire              use_position,
	input  wire              out_ready,
	output logic             out_valid,
	output logic             bus_valid,
	output logic             bus_rs,
	output logic [3:0]       bus_nibble,
	output logic [6:0]       cursor_position,
	output logic [7:0]       read_char,
	output logic             last
);
	import lcdfe_pkg::*;

	// request registers
	logic [3:0] req_q;
	logic [7:0] ch_q;
	logic [7:0] pos_q;
	logic [1:0] fsel_q;
	logic       fval_q;
	logic       usep_q;
	logic [7:0] arg_q;
	logic [6:0] saved_q;
	logic [7:0] arg_d;

	// architectural state
	logic [6:0] cursor_q;
	logic [2:0] flags_q;
	logic [SHADOW_CELLS-1:0] vld_q;
	logic [7:0] mem [SHADOW_CELLS];
	logic [7:0] mrd_q;
	logic       mvld_q;
	logic [7:0] rd_q;
	logic [7:0] dig_q;

	// transfer buffer and output register
	logic [4:0]       txb [TX_DEPTH];
	logic [TX_AW-1:0] wcnt_q, rptr_q, n_eff;
	logic             more;
	logic             ov_q, o_bv_q, o_rs_q, o_last_q;
	logic [3:0]       o_nib_q;

	// op evaluation
	logic [7:0]         tgt;
	logic               tgt_ok;
	logic [1:0]         t_row;
	logic [6:0]         t_col, ddr;
	logic [7:0]         sp_cmd, dch, fb, ib;
	logic [2:0]         newf, fbit;
	logic [7:0]         cell_byte, dig_n;
	logic               isdig, down, wrap;
	logic               emit, e_rs, done;
	logic [3:0]         e_nib;
	logic [CELL_AW-1:0] raddr;
	logic               rin;

	// set-address target and its ddram command
	always_comb begin
		case (cmd.op)
			OP_SP_SAVED: tgt = {1'b0, saved_q};
			OP_SP_CUR:   tgt = {1'b0, cursor_q};
			OP_STEPBACK: tgt = (cursor_q == 7'd0) ? 8'd0 : {1'b0, cursor_q - 7'd1};
			default:     tgt = arg_q;
		endcase
		tgt_ok = tgt < 8'(SHADOW_CELLS);
		t_row  = 2'(tgt / LINE_CELLS);
		t_col  = 7'(tgt % LINE_CELLS);
		ddr    = (t_row[0] ? ROW1_BASE : 7'd0) + (t_row[1] ? 7'(LINE_CELLS) : 7'd0) + t_col;
		sp_cmd = CMD_SET_DDRAM | {1'b0, ddr};
	end

	// data byte, flag update and digit check
	always_comb begin
		case (cmd.op)
			OP_DATA_SPACE: dch = CHAR_SPACE;
			OP_DATA_DIG:   dch = dig_q;
			default:       dch = ch_q;
		endcase
		fbit      = 3'(3'b001 << fsel_q);
		newf      = fval_q ? (flags_q | fbit) : (flags_q & ~fbit);
		fb        = CMD_DISPLAY | {5'd0, newf};
		ib        = CMD_DISPLAY | {5'd0, flags_q & FLAG_KEEP_MASK};
		cell_byte = mvld_q ? mrd_q : 8'd0;
		isdig     = (cell_byte >= CHAR_ZERO) && (cell_byte <= CHAR_NINE);
		down      = (req_q == REQ_DIG_DOWN);
		wrap      = down ? (cell_byte == CHAR_ZERO) : (cell_byte == CHAR_NINE);
		if (wrap) dig_n = down ? CHAR_NINE : CHAR_ZERO;
		else dig_n = down ? cell_byte - 8'd1 : cell_byte + 8'd1;
	end

	// nibble of the current op step
	always_comb begin
		emit  = 1'b0;
		e_rs  = 1'b0;
		e_nib = 4'd0;
		done  = (cmd.phase == 4'd1);
		unique case (cmd.op)
			OP_SP_ARG, OP_SP_SAVED, OP_SP_CUR, OP_STEPBACK: begin
				emit = 1'b1;
				if (tgt_ok) begin
					e_nib = (cmd.phase == 4'd0) ? sp_cmd[7:4] : sp_cmd[3:0];
				end else begin
					done = (cmd.phase == 4'd3);
					case (cmd.phase)
						4'd0:    e_nib = CMD_CLEAR[7:4];
						4'd1:    e_nib = CMD_CLEAR[3:0];
						4'd2:    e_nib = CMD_SET_DDRAM[7:4];
						default: e_nib = CMD_SET_DDRAM[3:0];
					endcase
				end
			end
			OP_DATA_IN, OP_DATA_SPACE, OP_DATA_DIG: begin
				emit  = 1'b1;
				e_rs  = 1'b1;
				e_nib = (cmd.phase == 4'd0) ? dch[7:4] : dch[3:0];
			end
			OP_CLEAR: begin
				emit  = 1'b1;
				e_nib = (cmd.phase == 4'd0) ? CMD_CLEAR[7:4] : CMD_CLEAR[3:0];
			end
			OP_FLAG: begin
				emit  = 1'b1;
				e_nib = (cmd.phase == 4'd0) ? fb[7:4] : fb[3:0];
			end
			OP_INIT: begin
				emit = 1'b1;
				done = (cmd.phase == 4'(INIT_LEN - 1));
				if (cmd.phase == 4'(INIT_LEN - 2)) e_nib = ib[7:4];
				else if (cmd.phase == 4'(INIT_LEN - 1)) e_nib = ib[3:0];
				else e_nib = init_nibble(cmd.phase);
			end
			default: ;
		endcase
	end

	// status to the controller
	always_comb begin
		stat.req     = req_q;
		stat.flag_ok = fsel_q < 2'(FLAG_SELS);
		stat.use_pos = usep_q;
		stat.op_done = done;
		if (cmd.op == OP_DIGIT && cmd.phase == 4'd1 && isdig)
			stat.dig = wrap ? DIG_WRAP : DIG_STEP;
		else
			stat.dig = DIG_NONE;
		case (req_q)
			REQ_UP:    stat.move_ok = cursor_q >= 7'(LINE_CELLS);
			REQ_DOWN:  stat.move_ok = cursor_q < 7'(SHADOW_CELLS - LINE_CELLS);
			REQ_LEFT:  stat.move_ok = 7'(cursor_q % LINE_CELLS) != 7'd0;
			REQ_RIGHT: stat.move_ok = 8'(({1'b0, cursor_q} + 8'd1) % LINE_CELLS) != 8'd0;
			default:   stat.move_ok = 1'b0;
		endcase
		stat.drain_done = !more && !ov_q;
	end

	// set-address argument of the request
	always_comb begin
		case (req_type)
			REQ_SETXY: arg_d = 8'(32'(row) * LINE_CELLS + 32'(column));
			REQ_UP:    arg_d = {1'b0, cursor_q} - 8'(LINE_CELLS);
			REQ_DOWN:  arg_d = {1'b0, cursor_q} + 8'(LINE_CELLS);
			REQ_LEFT:  arg_d = {1'b0, cursor_q} - 8'd1;
			REQ_RIGHT: arg_d = {1'b0, cursor_q} + 8'd1;
			default:   arg_d = position;
		endcase
	end

	// request capture and op results held as payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			ch_q    <= char_code;
			pos_q   <= position;
			fsel_q  <= flag_select;
			fval_q  <= flag_value;
			usep_q  <= use_position;
			arg_q   <= arg_d;
			saved_q <= cursor_q;
			rd_q    <= 8'd0;
		end else if (cmd.exec && done) begin
			if (cmd.op == OP_DIGIT) dig_q <= dig_n;
			if (cmd.op == OP_READ) rd_q <= cell_byte;
		end
	end

	// shadow memory with registered read
	always_comb begin
		raddr = (cmd.op == OP_READ) ? pos_q[CELL_AW-1:0] : cursor_q[CELL_AW-1:0];
		rin   = (cmd.op == OP_READ) ? (pos_q < 8'(SHADOW_CELLS))
		                            : (cursor_q < 7'(SHADOW_CELLS));
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && done && (cmd.op == OP_DATA_IN || cmd.op == OP_DATA_SPACE ||
		                         cmd.op == OP_DATA_DIG))
			mem[cursor_q[CELL_AW-1:0]] <= dch;
		if (cmd.exec) begin
			mrd_q  <= mem[raddr];
			mvld_q <= vld_q[raddr] && rin;
		end
	end

	// cursor, flags and cell valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= 7'd0;
			flags_q  <= FLAG_RESET;
			vld_q    <= '0;
		end else if (cmd.exec && done) begin
			case (cmd.op)
				OP_SP_ARG, OP_SP_SAVED, OP_SP_CUR, OP_STEPBACK: begin
					if (tgt_ok) begin
						cursor_q <= tgt[6:0];
					end else begin
						cursor_q <= 7'd0;
						vld_q    <= '0;
					end
				end
				OP_DATA_IN, OP_DATA_SPACE, OP_DATA_DIG: begin
					vld_q[cursor_q[CELL_AW-1:0]] <= 1'b1;
					cursor_q <= cursor_q + 7'd1;
				end
				OP_CLEAR: begin
					cursor_q <= 7'd0;
					vld_q    <= '0;
				end
				OP_FLAG: flags_q <= newf;
				OP_INIT: begin
					flags_q  <= flags_q & FLAG_KEEP_MASK;
					cursor_q <= 7'd0;
				end
				default: ;
			endcase
		end
	end

	// transfer buffer write
	always_ff @(posedge clk) begin
		if (cmd.exec && emit) txb[wcnt_q[TX_AW-1:0]] <= {e_rs, e_nib};
	end

	// drain bookkeeping
	always_comb begin
		n_eff = (wcnt_q == '0) ? TX_AW'(1) : wcnt_q;
		more  = rptr_q < n_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			rptr_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				wcnt_q <= '0;
				rptr_q <= '0;
			end else if (cmd.exec && emit) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			if (cmd.drain && (!ov_q || out_ready)) begin
				ov_q <= more;
				if (more) rptr_q <= rptr_q + 1'b1;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.drain && (!ov_q || out_ready) && more) begin
			o_bv_q   <= (wcnt_q != '0);
			o_rs_q   <= (wcnt_q != '0) && txb[rptr_q][4];
			o_nib_q  <= (wcnt_q != '0) ? txb[rptr_q][3:0] : 4'd0;
			o_last_q <= (rptr_q + 1'b1 == n_eff);
		end
	end

	// outputs
	always_comb begin
		out_valid       = ov_q;
		bus_valid       = o_bv_q;
		bus_rs          = o_rs_q;
		bus_nibble      = o_nib_q;
		last            = o_last_q;
		cursor_position = cursor_q;
		read_char       = rd_q;
	end

endmodule
`default_nettype wire

// ===== rtl/core/char_lcd_command_front_end.sv =====
// top level of the character lcd command front end
//
// channel   direction  handshake              payload
// request   in         in_valid / in_ready    req_type char_code position column row
//                                             flag_select flag_value use_position
// transfer  out        out_valid / out_ready  bus_valid bus_rs bus_nibble cursor_position
//                                             read_char last
//
// one request at a time: it is captured, decoded into an op list, and each op step
// writes one nibble to the transfer buffer (a digit check or cell read writes none);
// once the op list closes, the buffer drains through the output register.
// a clear drops all 64 cell valid bits at once, so no clearing pass after reset.
// a stall on the transfer side holds the output register; requests wait meanwhile.
`default_nettype none
module char_lcd_command_front_end (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [3:0] req_type,
	input  wire  [7:0] char_code,
	input  wire  [7:0] position,
	input  wire  [3:0] column,
	input  wire  [3:0] row,
	input  wire  [1:0] flag_select,
	input  wire        flag_value,
	input  wire        use_position,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       bus_valid,
	output logic       bus_rs,
	output logic [3:0] bus_nibble,
	output logic [6:0] cursor_position,
	output logic [7:0] read_char,
	output logic       last
);
	import lcdfe_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// controller
	lcdfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	lcdfe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_type        (req_type),
		.char_code       (char_code),
		.position        (position),
		.column          (column),
		.row             (row),
		.flag_select     (flag_select),
		.flag_value      (flag_value),
		.use_position    (use_position),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.bus_valid       (bus_valid),
		.bus_rs          (bus_rs),
		.bus_nibble      (bus_nibble),
		.cursor_position (cursor_position),
		.read_char       (read_char),
		.last            (last)
	);

endmodule
`default_nettype wire
